// ===== rtl/core/pbh_pkg.sv =====
package pbh_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int OUT_BITS = 16;
    localparam int AXES = 3;

    localparam int LEAF_CFG_BITS = 13;
    localparam int GROUP_CFG_BITS = 9;
    localparam int LEAF_CNT_BITS = 12;
    localparam int GROUP_CNT_BITS = 8;

    localparam logic [LEAF_CFG_BITS-1:0] LEAF_CAP = 13'd4096;
    localparam logic [GROUP_CFG_BITS-1:0] GROUP_CAP = 9'd256;
    localparam logic [LEAF_CFG_BITS-1:0] LEAF_RESET = 13'd64;
    localparam logic [GROUP_CFG_BITS-1:0] GROUP_RESET = 9'd64;

    localparam int ADDR_BITS = 3;
    localparam logic REG_LEAF_POINTS = 1'b0;
    localparam logic REG_GROUP_LEAVES = 1'b1;

    localparam logic BOX_LEAF = 1'b0;
    localparam logic BOX_GROUP = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic [15:0] z_coord;
        logic        final_point;
    } pbh_point_t;

    typedef struct packed {
        logic        box_kind;
        logic [15:0] min_x;
        logic [15:0] min_y;
        logic [15:0] min_z;
        logic [15:0] max_x;
        logic [15:0] max_y;
        logic [15:0] max_z;
        logic        run_end;
    } pbh_box_t;

    typedef struct packed {
        logic [LEAF_CFG_BITS-1:0]  leaf_points;
        logic [GROUP_CFG_BITS-1:0] group_leaves;
    } pbh_cfg_t;

    typedef struct packed {
        logic     push;
        logic     push_two;
        pbh_box_t first;
        pbh_box_t second;
    } pbh_push_t;

    function automatic logic [LEAF_CFG_BITS-1:0] leaf_limit(
        input logic [LEAF_CFG_BITS-1:0] v
    );
        logic [LEAF_CFG_BITS-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = LEAF_CFG_BITS'(1);
        end
        else if (v > LEAF_CAP)
        begin
            r = LEAF_CAP;
        end
        return r;
    endfunction

    function automatic logic [GROUP_CFG_BITS-1:0] group_limit(
        input logic [GROUP_CFG_BITS-1:0] v
    );
        logic [GROUP_CFG_BITS-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = GROUP_CFG_BITS'(1);
        end
        else if (v > GROUP_CAP)
        begin
            r = GROUP_CAP;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/point_box_hierarchy_builder.sv =====
// Builds leaf and group bounding boxes from a stream of 3D points.
// Points enter on the point channel (point_valid, point_ready, point) and
// boxes leave on the box channel (box_valid, box_ready, box); an item moves
// when valid and ready are both high at a rising edge of clk.
// A point that closes a leaf gives one leaf box item; one that also closes
// a group gives the leaf box and then the group box. run_end marks the last
// item that a point causes.
// A box item is written into the result queue when the point that closes it
// is accepted, and is offered once the items ahead of it have left. One point
// is taken every cycle while the queue has room for two items; the limit is
// the output side, which moves one box item a cycle while box_ready is high,
// so a point that closes a group gives it two items. A four-entry result
// queue sits between the box update logic and the output.
// When the receiver stalls, queued items are held and point_ready falls once
// the queue cannot take two more.
// The APB port sets leaf_points (address 0) and group_leaves (address 4).
// Reset, asynchronous and active low, empties the queue, returns both boxes
// to empty, clears the counters and sets both limits to 64.
module point_box_hierarchy_builder #(
    parameter int COORD_BITS = pbh_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          point_valid,
    output logic                          point_ready,
    input  pbh_pkg::pbh_point_t           point,
    output logic                          box_valid,
    input  logic                          box_ready,
    output pbh_pkg::pbh_box_t             box,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbh_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    pbh_pkg::pbh_cfg_t  cfg;
    pbh_pkg::pbh_push_t push;
    logic               accept;

    assign accept = point_valid && point_ready;

    pbh_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbh_box_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_box (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .point  (point),
        .cfg    (cfg),
        .push   (push)
    );

    pbh_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (point_ready),
        .box_valid (box_valid),
        .box_ready (box_ready),
        .box       (box)
    );

    // A leaf box that does not end its run is followed by its group box.
    assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && box_ready && box.box_kind == pbh_pkg::BOX_LEAF && !box.run_end)
        |=> (box_valid && box.box_kind == pbh_pkg::BOX_GROUP))
        else $error("group box missing after leaf box");

    // A group box always ends the run of its point.
    assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && box.box_kind == pbh_pkg::BOX_GROUP) |-> box.run_end)
        else $error("group box without run end");

    // The point channel only stalls while results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> box_valid)
        else $error("input stalled with empty result queue");

    // A point marked final closes a run ending in a group box; box_valid must follow.
    assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_ready && point.final_point) |=> box_valid)
        else $error("final point produced no box");

endmodule

// ===== rtl/core/pbh_cfg_regs.sv =====
module pbh_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbh_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pbh_pkg::pbh_cfg_t             cfg
);

    logic [pbh_pkg::LEAF_CFG_BITS-1:0]  leaf_points_reg;
    logic [pbh_pkg::GROUP_CFG_BITS-1:0] group_leaves_reg;
    logic                               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_points_reg  <= pbh_pkg::LEAF_RESET;
            group_leaves_reg <= pbh_pkg::GROUP_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                pbh_pkg::REG_LEAF_POINTS:
                begin
                    leaf_points_reg <= pwdata[pbh_pkg::LEAF_CFG_BITS-1:0];
                end
                pbh_pkg::REG_GROUP_LEAVES:
                begin
                    group_leaves_reg <= pwdata[pbh_pkg::GROUP_CFG_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            pbh_pkg::REG_LEAF_POINTS:
            begin
                prdata = 32'(leaf_points_reg);
            end
            pbh_pkg::REG_GROUP_LEAVES:
            begin
                prdata = 32'(group_leaves_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.leaf_points  = leaf_points_reg;
    assign cfg.group_leaves = group_leaves_reg;

endmodule

// ===== rtl/core/pbh_box_unit.sv =====
module pbh_box_unit #(
    parameter int COORD_BITS = pbh_pkg::COORD_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  pbh_pkg::pbh_point_t point,
    input  pbh_pkg::pbh_cfg_t   cfg,
    output pbh_pkg::pbh_push_t  push
);

    localparam int W = COORD_BITS;
    localparam int OB = pbh_pkg::OUT_BITS;

    logic [W-1:0] leaf_lo_reg [pbh_pkg::AXES];
    logic [W-1:0] leaf_hi_reg [pbh_pkg::AXES];
    logic [W-1:0] group_lo_reg [pbh_pkg::AXES];
    logic [W-1:0] group_hi_reg [pbh_pkg::AXES];
    logic [pbh_pkg::LEAF_CNT_BITS-1:0]  points_in_leaf_reg;
    logic [pbh_pkg::LEAF_CNT_BITS-1:0]  points_in_leaf_next;
    logic [pbh_pkg::GROUP_CNT_BITS-1:0] leaves_in_group_reg;
    logic [pbh_pkg::GROUP_CNT_BITS-1:0] leaves_in_group_next;

    logic [OB-1:0]    coord_in [pbh_pkg::AXES];
    logic [W+OB-1:0]  coord_ext [pbh_pkg::AXES];
    logic [W-1:0]     pt [pbh_pkg::AXES];
    logic [W-1:0]     leaf_lo_new [pbh_pkg::AXES];
    logic [W-1:0]     leaf_hi_new [pbh_pkg::AXES];
    logic [W-1:0]     group_lo_new [pbh_pkg::AXES];
    logic [W-1:0]     group_hi_new [pbh_pkg::AXES];
    logic [W+OB-1:0]  out_ext [4][pbh_pkg::AXES];
    logic [OB-1:0]    out_val [4][pbh_pkg::AXES];

    logic [pbh_pkg::LEAF_CFG_BITS-1:0]  leaf_lim;
    logic [pbh_pkg::GROUP_CFG_BITS-1:0] group_lim;
    logic [pbh_pkg::LEAF_CFG_BITS-1:0]  leaf_count_inc;
    logic [pbh_pkg::GROUP_CFG_BITS-1:0] group_count_inc;
    logic                               leaf_close;
    logic                               group_close;

    assign coord_in[0] = point.x_coord;
    assign coord_in[1] = point.y_coord;
    assign coord_in[2] = point.z_coord;

    assign leaf_lim        = pbh_pkg::leaf_limit(cfg.leaf_points);
    assign group_lim       = pbh_pkg::group_limit(cfg.group_leaves);
    assign leaf_count_inc  = pbh_pkg::LEAF_CFG_BITS'(points_in_leaf_reg) + 1'b1;
    assign group_count_inc = pbh_pkg::GROUP_CFG_BITS'(leaves_in_group_reg) + 1'b1;
    assign leaf_close      = point.final_point || (leaf_count_inc >= leaf_lim);
    assign group_close     = point.final_point || (group_count_inc >= group_lim);

    always_comb
    begin
        for (int a = 0; a < pbh_pkg::AXES; a++)
        begin
            coord_ext[a] = {{W{1'b0}}, coord_in[a]};
            pt[a] = coord_ext[a][W-1:0];
            leaf_lo_new[a] = (pt[a] < leaf_lo_reg[a]) ? pt[a] : leaf_lo_reg[a];
            leaf_hi_new[a] = (pt[a] > leaf_hi_reg[a]) ? pt[a] : leaf_hi_reg[a];
            group_lo_new[a] = (leaf_lo_new[a] < group_lo_reg[a]) ?
                              leaf_lo_new[a] : group_lo_reg[a];
            group_hi_new[a] = (leaf_hi_new[a] > group_hi_reg[a]) ?
                              leaf_hi_new[a] : group_hi_reg[a];
            out_ext[0][a] = {{OB{1'b0}}, leaf_lo_new[a]};
            out_ext[1][a] = {{OB{1'b0}}, leaf_hi_new[a]};
            out_ext[2][a] = {{OB{1'b0}}, group_lo_new[a]};
            out_ext[3][a] = {{OB{1'b0}}, group_hi_new[a]};
            for (int k = 0; k < 4; k++)
            begin
                out_val[k][a] = out_ext[k][a][OB-1:0];
            end
        end
    end

    always_comb
    begin
        push.push            = accept && leaf_close;
        push.push_two        = accept && leaf_close && group_close;
        push.first.box_kind  = pbh_pkg::BOX_LEAF;
        push.first.min_x     = out_val[0][0];
        push.first.min_y     = out_val[0][1];
        push.first.min_z     = out_val[0][2];
        push.first.max_x     = out_val[1][0];
        push.first.max_y     = out_val[1][1];
        push.first.max_z     = out_val[1][2];
        push.first.run_end   = !group_close;
        push.second.box_kind = pbh_pkg::BOX_GROUP;
        push.second.min_x    = out_val[2][0];
        push.second.min_y    = out_val[2][1];
        push.second.min_z    = out_val[2][2];
        push.second.max_x    = out_val[3][0];
        push.second.max_y    = out_val[3][1];
        push.second.max_z    = out_val[3][2];
        push.second.run_end  = 1'b1;
    end

    always_comb
    begin
        points_in_leaf_next  = points_in_leaf_reg;
        leaves_in_group_next = leaves_in_group_reg;
        if (!leaf_close)
        begin
            points_in_leaf_next = leaf_count_inc[pbh_pkg::LEAF_CNT_BITS-1:0];
        end
        else
        begin
            points_in_leaf_next = '0;
            if (group_close)
            begin
                leaves_in_group_next = '0;
            end
            else
            begin
                leaves_in_group_next = group_count_inc[pbh_pkg::GROUP_CNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < pbh_pkg::AXES; a++)
            begin
                leaf_lo_reg[a]  <= '1;
                leaf_hi_reg[a]  <= '0;
                group_lo_reg[a] <= '1;
                group_hi_reg[a] <= '0;
            end
            points_in_leaf_reg  <= '0;
            leaves_in_group_reg <= '0;
        end
        else if (accept)
        begin
            points_in_leaf_reg  <= points_in_leaf_next;
            leaves_in_group_reg <= leaves_in_group_next;
            for (int a = 0; a < pbh_pkg::AXES; a++)
            begin
                if (!leaf_close)
                begin
                    leaf_lo_reg[a] <= leaf_lo_new[a];
                    leaf_hi_reg[a] <= leaf_hi_new[a];
                end
                else
                begin
                    leaf_lo_reg[a] <= '1;
                    leaf_hi_reg[a] <= '0;
                    if (group_close)
                    begin
                        group_lo_reg[a] <= '1;
                        group_hi_reg[a] <= '0;
                    end
                    else
                    begin
                        group_lo_reg[a] <= group_lo_new[a];
                        group_hi_reg[a] <= group_hi_new[a];
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/pbh_out_queue.sv =====
module pbh_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  pbh_pkg::pbh_push_t push,
    output logic               space,
    output logic               box_valid,
    input  logic               box_ready,
    output pbh_pkg::pbh_box_t  box
);

    localparam int IB = pbh_pkg::QUEUE_IDX_BITS;
    localparam int CB = pbh_pkg::QUEUE_CNT_BITS;

    pbh_pkg::pbh_box_t entry_reg [pbh_pkg::QUEUE_DEPTH];
    logic [IB-1:0] wr_ptr_reg;
    logic [IB-1:0] wr_ptr_next;
    logic [IB-1:0] wr_ptr_plus;
    logic [IB-1:0] rd_ptr_reg;
    logic [IB-1:0] rd_ptr_next;
    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;
    logic          pop;

    assign space       = count_reg <= CB'(pbh_pkg::QUEUE_DEPTH - 2);
    assign box_valid   = count_reg != '0;
    assign box         = entry_reg[rd_ptr_reg];
    assign pop         = box_valid && box_ready;
    assign wr_ptr_plus = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + IB'(push.push) + IB'(push.push_two);
        rd_ptr_next = rd_ptr_reg + IB'(pop);
        count_next  = count_reg + CB'(push.push) + CB'(push.push_two) - CB'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.push_two)
        begin
            entry_reg[wr_ptr_plus] <= push.second;
        end
    end

endmodule

// ===== tb/tb_point_box_hierarchy_builder.sv =====
`timescale 1ns / 100ps

module tb_point_box_hierarchy_builder;

    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic point_valid = 1'b0;
    logic point_ready;
    pbh_pkg::pbh_point_t point_in = '0;
    logic box_valid;
    logic box_ready = 1'b0;
    pbh_pkg::pbh_box_t box_out;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pbh_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    point_box_hierarchy_builder dut (
        .clk(clk),
        .rst_n(rst_n),
        .point_valid(point_valid),
        .point_ready(point_ready),
        .point(point_in),
        .box_valid(box_valid),
        .box_ready(box_ready),
        .box(box_out),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Predictor state, kept in step with the block.
    logic [pbh_pkg::LEAF_CFG_BITS-1:0] leaf_cfg = pbh_pkg::LEAF_RESET;
    logic [pbh_pkg::GROUP_CFG_BITS-1:0] group_cfg = pbh_pkg::GROUP_RESET;
    logic [pbh_pkg::AXES-1:0][15:0] leaf_min = '1;
    logic [pbh_pkg::AXES-1:0][15:0] leaf_max = '0;
    logic [pbh_pkg::AXES-1:0][15:0] group_min = '1;
    logic [pbh_pkg::AXES-1:0][15:0] group_max = '0;
    int unsigned leaf_fill = 0;
    int unsigned group_fill = 0;

    pbh_pkg::pbh_point_t pending_points[$];
    pbh_pkg::pbh_box_t expected_boxes[$];

    bit point_went = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned send_gap_max = 0;

    bit hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned ready_run = 0;
    int unsigned stall_run = 0;
    int unsigned recv_stall_max = 0;

    int unsigned mismatches = 0;
    int unsigned points_taken = 0;
    int unsigned leaf_boxes = 0;
    int unsigned group_boxes = 0;
    int unsigned settings_used = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic pbh_pkg::pbh_box_t make_box(
        input logic kind,
        input logic [pbh_pkg::AXES-1:0][15:0] lo,
        input logic [pbh_pkg::AXES-1:0][15:0] hi
    );
        pbh_pkg::pbh_box_t b;
        b.box_kind = kind;
        b.min_x = lo[0];
        b.min_y = lo[1];
        b.min_z = lo[2];
        b.max_x = hi[0];
        b.max_y = hi[1];
        b.max_z = hi[2];
        b.run_end = 1'b0;
        return b;
    endfunction

    task automatic fold_point(input pbh_pkg::pbh_point_t p);
        logic [pbh_pkg::AXES-1:0][15:0] c;
        pbh_pkg::pbh_box_t leaf_box;
        pbh_pkg::pbh_box_t group_box;
        int unsigned leaf_lim;
        int unsigned group_lim;
        c[0] = p.x_coord;
        c[1] = p.y_coord;
        c[2] = p.z_coord;
        leaf_lim = (leaf_cfg == '0) ? 1 :
                   ((leaf_cfg > pbh_pkg::LEAF_CAP) ? int'(pbh_pkg::LEAF_CAP) :
                                                     int'(leaf_cfg));
        group_lim = (group_cfg == '0) ? 1 :
                    ((group_cfg > pbh_pkg::GROUP_CAP) ? int'(pbh_pkg::GROUP_CAP) :
                                                        int'(group_cfg));
        for (int a = 0; a < pbh_pkg::AXES; a++)
        begin
            if (c[a] < leaf_min[a]) leaf_min[a] = c[a];
            if (c[a] > leaf_max[a]) leaf_max[a] = c[a];
        end
        if (!p.final_point && leaf_fill + 1 < leaf_lim)
        begin
            leaf_fill++;
            return;
        end
        leaf_box = make_box(pbh_pkg::BOX_LEAF, leaf_min, leaf_max);
        for (int a = 0; a < pbh_pkg::AXES; a++)
        begin
            if (leaf_min[a] < group_min[a]) group_min[a] = leaf_min[a];
            if (leaf_max[a] > group_max[a]) group_max[a] = leaf_max[a];
        end
        leaf_min = '1;
        leaf_max = '0;
        leaf_fill = 0;
        if (p.final_point || group_fill + 1 >= group_lim)
        begin
            group_box = make_box(pbh_pkg::BOX_GROUP, group_min, group_max);
            group_box.run_end = 1'b1;
            expected_boxes.push_back(leaf_box);
            expected_boxes.push_back(group_box);
            group_min = '1;
            group_max = '0;
            group_fill = 0;
        end
        else
        begin
            leaf_box.run_end = 1'b1;
            expected_boxes.push_back(leaf_box);
            group_fill++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
        begin
            $display("Mismatch at box %0d, %s: got %h, expected %h",
                     leaf_boxes + group_boxes, what, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && point_valid && point_ready)
        begin
            fold_point(point_in);
            points_taken++;
            point_went = 1'b1;
        end
        if (rst_n && point_valid && !point_ready)
        begin
            input_stall_cycles++;
        end
    end

    always @(negedge clk)
    begin : point_driver
        logic nxt_valid;
        pbh_pkg::pbh_point_t nxt_point;
        nxt_valid = point_valid;
        nxt_point = point_in;
        if (point_went)
        begin
            nxt_valid = 1'b0;
            point_went = 1'b0;
        end
        if (rst_n && !nxt_valid)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_points.size() > 0)
            begin
                nxt_point = pending_points.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = $urandom_range(0, send_gap_max);
                end
            end
        end
        point_valid <= nxt_valid;
        point_in <= nxt_point;
    end

    always @(negedge clk)
    begin : box_receiver
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD - 1;
            end
            else if (ready_run > 0)
            begin
                ready_run--;
                nxt_ready = 1'b1;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
            end
            else
            begin
                ready_run = $urandom_range(1, 16);
                stall_run = $urandom_range(0, recv_stall_max);
                nxt_ready = 1'b1;
            end
        end
        box_ready <= nxt_ready;
    end

    always @(posedge clk)
    begin : box_monitor
        pbh_pkg::pbh_box_t want;
        if (rst_n && box_valid && box_ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                report_mismatch("box with nothing expected", box_out.min_x, '0);
            end
            else
            begin
                want = expected_boxes.pop_front();
                if (box_out.box_kind !== want.box_kind)
                    report_mismatch("box_kind", 16'(box_out.box_kind), 16'(want.box_kind));
                if (box_out.min_x !== want.min_x)
                    report_mismatch("min_x", box_out.min_x, want.min_x);
                if (box_out.min_y !== want.min_y)
                    report_mismatch("min_y", box_out.min_y, want.min_y);
                if (box_out.min_z !== want.min_z)
                    report_mismatch("min_z", box_out.min_z, want.min_z);
                if (box_out.max_x !== want.max_x)
                    report_mismatch("max_x", box_out.max_x, want.max_x);
                if (box_out.max_y !== want.max_y)
                    report_mismatch("max_y", box_out.max_y, want.max_y);
                if (box_out.max_z !== want.max_z)
                    report_mismatch("max_z", box_out.max_z, want.max_z);
                if (box_out.run_end !== want.run_end)
                    report_mismatch("run_end", 16'(box_out.run_end), 16'(want.run_end));
            end
            if (box_out.box_kind === pbh_pkg::BOX_GROUP) group_boxes++;
            else leaf_boxes++;
        end
    end

    task automatic write_reg(input logic reg_idx, input int unsigned value);
        logic [31:0] wdata;
        wdata = $urandom;
        if (reg_idx == pbh_pkg::REG_LEAF_POINTS)
            wdata[pbh_pkg::LEAF_CFG_BITS-1:0] = pbh_pkg::LEAF_CFG_BITS'(value);
        else
            wdata[pbh_pkg::GROUP_CFG_BITS-1:0] = pbh_pkg::GROUP_CFG_BITS'(value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (reg_idx == pbh_pkg::REG_LEAF_POINTS)
            leaf_cfg = wdata[pbh_pkg::LEAF_CFG_BITS-1:0];
        else
            group_cfg = wdata[pbh_pkg::GROUP_CFG_BITS-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_limits(input int unsigned leaf_val, input int unsigned group_val);
        write_reg(pbh_pkg::REG_LEAF_POINTS, leaf_val);
        write_reg(pbh_pkg::REG_GROUP_LEAVES, group_val);
        settings_used++;
    endtask

    task automatic wait_idle;
        do @(posedge clk);
        while (pending_points.size() != 0 || point_valid || expected_boxes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_point(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic fin);
        pbh_pkg::pbh_point_t p;
        p.x_coord = x;
        p.y_coord = y;
        p.z_coord = z;
        p.final_point = fin;
        pending_points.push_back(p);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly complete point sets of random length; now and then a set is
    // left open so that it runs on into the next one or the next setting.
    task automatic queue_point_sets(input int unsigned count);
        int unsigned left;
        int unsigned len;
        bit open_set;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(1, 40);
            if (len > left) len = left;
            open_set = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++)
                push_point(rand_coord(), rand_coord(), rand_coord(),
                           (i == len - 1) && !open_set);
            left -= len;
        end
    endtask

    initial
    begin
        int unsigned leaf_choice[8];
        int unsigned group_choice[8];
        pbh_pkg::pbh_box_t lost_box;
        leaf_choice = '{1, 0, 4096, 8191, 3, 2, 5, 13};
        group_choice = '{2, 1, 0, 256, 3, 511, 4, 2};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        push_point(16'h5555, 16'hAAAA, 16'h0F0F, 1'b0);
        push_point(16'hAAAA, 16'h5555, 16'hF0F0, 1'b1);
        wait_idle();

        set_limits(0, 0);
        push_point(16'h1234, 16'h0000, 16'hFFFF, 1'b0);
        push_point(16'hFFFF, 16'h0000, 16'h0001, 1'b1);
        wait_idle();

        set_limits(2, 3);
        push_point(16'h0000, 16'hFFFF, 16'h8000, 1'b0);
        push_point(16'h7FFF, 16'h8000, 16'h0001, 1'b0);
        push_point(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        push_point(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        push_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
        push_point(16'h0001, 16'h0002, 16'h0003, 1'b0);
        push_point(16'hFFFE, 16'hFFFD, 16'h0004, 1'b1);
        wait_idle();

        set_limits(8191, 511);
        push_point(16'h0100, 16'hFF00, 16'h00FF, 1'b0);
        push_point(16'hFFFF, 16'h0000, 16'h7777, 1'b0);
        push_point(16'h0000, 16'hFFFF, 16'h8888, 1'b1);
        wait_idle();

        // Leaf and group left open, then their limits lowered to or below the count.
        set_limits(6, 4);
        for (int i = 0; i < 5; i++)
            push_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        wait_idle();
        set_limits(2, 4);
        push_point(16'h4321, 16'h0000, 16'hFFFF, 1'b0);
        wait_idle();
        set_limits(2, 1);
        push_point(16'hFFFF, 16'h1111, 16'h0000, 1'b0);
        push_point(16'h0000, 16'hEEEE, 16'hFFFF, 1'b0);
        wait_idle();

        // Receiver holds off while the sender keeps offering items.
        set_limits(1, 2);
        send_gap_max = 0;
        burst_left = 0;
        hold_request = 1'b1;
        queue_point_sets(40);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            send_gap_max = (phase == 0) ? 0 : $urandom_range(1, 8);
            recv_stall_max = (phase == 0) ? 0 : $urandom_range(1, 8);
            set_limits(leaf_choice[phase], group_choice[phase]);
            queue_point_sets(50);
            wait_idle();
        end

        // Group closed by its count at the saturated limit.
        send_gap_max = 2;
        recv_stall_max = 3;
        set_limits(1, 511);
        for (int i = 0; i < 260; i++)
            push_point(rand_coord(), rand_coord(), rand_coord(), i == 259);
        wait_idle();

        while (expected_boxes.size() != 0)
        begin
            lost_box = expected_boxes.pop_front();
            report_mismatch("expected box never came", lost_box.min_x, '0);
        end

        $display("Checked %0d points giving %0d leaf and %0d group boxes under %0d settings.",
                 points_taken, leaf_boxes, group_boxes, settings_used);
        $display("Input was held back for %0d cycles, including a %0d-cycle receiver hold-off.",
                 input_stall_cycles, LONG_HOLD);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
